[rtl/core/session_table_with_pool_and_aging_assert.svh]
// Assertion macros for the checker file.
`ifndef SESSION_TABLE_WITH_POOL_AND_AGING_ASSERT_SVH
`define SESSION_TABLE_WITH_POOL_AND_AGING_ASSERT_SVH

// Plain clocked property, disabled while reset is asserted.
`define STPA_ASSERT(lbl, clk_s, rst_n, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (prop)) \
		else $error("stpa assertion failed");

// Condition in one cycle implies a condition in the next.
`define STPA_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	`STPA_ASSERT(lbl, clk_s, rst_n, (ante) |=> (cons))

`endif

[rtl/core/stpa_pkg.sv]
`timescale 1ns / 1ps

package stpa_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [31:0] POOL_FIRST_RESET = 32'h0a08_0002;
	localparam logic [31:0] POOL_LAST_RESET = 32'h0a08_00ff;
	localparam logic [31:0] TIMEOUT_RESET = 32'd60;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_LAST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd2;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_FIND_TUN = 3'd1;
	localparam logic [2:0] OP_FIND_PEER = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_SWEEP = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_REFRESHED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NO_SLOT = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
		logic [31:0] tunnel_addr;
		logic [31:0] now_time;
	} in_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] addr_out;
		logic [4:0] slot_out;
		logic [31:0] peer_ip_out;
		logic [15:0] peer_port_out;
		logic [5:0] expired_count;
	} out_rsp_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic commit;
	} dp_cmd_t;

	function automatic logic [4:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [31:0] w;
		w = 32'(idx);
		return w[4:0];
	endfunction

	function automatic logic [5:0] to_count(input logic [CNT_W-1:0] cnt);
		logic [31:0] w;
		w = 32'(cnt);
		return w[5:0];
	endfunction

endpackage

[rtl/core/stpa_ctrl.sv]
`timescale 1ns / 1ps

module stpa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output stpa_pkg::dp_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	localparam logic [stpa_pkg::IDX_W-1:0] LAST_IDX =
		stpa_pkg::IDX_W'(stpa_pkg::TABLE_ENTRIES - 1);

	logic [1:0] state_q;
	logic [stpa_pkg::IDX_W-1:0] rd_idx_q;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.rd_en = (state_q == S_SCAN);
		cmd.rd_idx = rd_idx_q;
		cmd.commit = (state_q == S_COMMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						rd_idx_q <= '0;
					end
				end
				S_SCAN: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				// last read data is evaluated at the end of this cycle
				S_DRAIN: state_q <= S_COMMIT;
				S_COMMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/stpa_dp.sv]
`timescale 1ns / 1ps

module stpa_dp (
	input logic clk,
	input logic arst_n,
	input stpa_pkg::dp_cmd_t cmd,
	input stpa_pkg::in_req_t in_data,
	input logic cfg_we,
	input logic [stpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output stpa_pkg::out_rsp_t out_data
);

	localparam int N = stpa_pkg::TABLE_ENTRIES;
	localparam int IW = stpa_pkg::IDX_W;
	localparam int CW = stpa_pkg::CNT_W;

	logic [31:0] pool_first_q, pool_last_q, timeout_q;
	logic [31:0] next_pool_q;
	logic [CW-1:0] active_total_q;
	logic [N-1:0] active_q;

	logic [31:0] mem_tun [N];
	logic [31:0] mem_ip [N];
	logic [15:0] mem_port [N];
	logic [31:0] mem_seen [N];

	stpa_pkg::in_req_t req_q;
	stpa_pkg::out_rsp_t out_q;

	logic rd_en_s1;
	logic [IW-1:0] idx_s1;
	logic act_s1;
	logic [31:0] tun_s1, ip_s1, seen_s1;
	logic [15:0] port_s1;

	logic found_q, free_found_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [31:0] hit_tun_q, hit_ip_q;
	logic [15:0] hit_port_q;
	logic [CW-1:0] expired_q;

	logic tun_hit, peer_hit, sel_hit, expire;
	logic [31:0] age, cand;
	logic is_full;
	logic do_refresh, do_insert, do_remove;
	logic seen_we;
	logic [IW-1:0] seen_idx;
	stpa_pkg::out_rsp_t rsp;

	assign out_data = out_q;

	assign tun_hit = act_s1 && (tun_s1 == req_q.tunnel_addr);
	assign peer_hit = act_s1 && (ip_s1 == req_q.peer_ip) && (port_s1 == req_q.peer_port);
	assign sel_hit = (req_q.op == stpa_pkg::OP_ADD || req_q.op == stpa_pkg::OP_FIND_PEER)
		? peer_hit : tun_hit;
	assign age = req_q.now_time - seen_s1;
	assign expire = rd_en_s1 && (req_q.op == stpa_pkg::OP_SWEEP) && act_s1 && (age > timeout_q);

	assign cand = (next_pool_q > pool_last_q) ? pool_first_q : next_pool_q;
	assign is_full = (active_total_q >= CW'(N));

	assign do_refresh = cmd.commit && (req_q.op == stpa_pkg::OP_ADD) && !is_full && found_q;
	assign do_insert = cmd.commit && (req_q.op == stpa_pkg::OP_ADD) && !is_full &&
		!found_q && free_found_q;
	assign do_remove = cmd.commit && (req_q.op == stpa_pkg::OP_REMOVE) && found_q;

	assign seen_we = do_refresh || do_insert;
	assign seen_idx = do_refresh ? hit_idx_q : free_idx_q;

	// result of the finished scan
	always_comb begin
		rsp = '0;
		rsp.status = stpa_pkg::ST_NOT_FOUND;
		case (req_q.op)
			stpa_pkg::OP_ADD: begin
				if (is_full) begin
					rsp.status = stpa_pkg::ST_FULL;
				end else if (found_q) begin
					rsp.status = stpa_pkg::ST_REFRESHED;
					rsp.addr_out = hit_tun_q;
					rsp.slot_out = stpa_pkg::to_slot(hit_idx_q);
				end else if (free_found_q) begin
					rsp.status = stpa_pkg::ST_OK;
					rsp.addr_out = cand;
					rsp.slot_out = stpa_pkg::to_slot(free_idx_q);
				end else begin
					rsp.status = stpa_pkg::ST_NO_SLOT;
				end
			end
			stpa_pkg::OP_FIND_TUN, stpa_pkg::OP_FIND_PEER: begin
				if (found_q) begin
					rsp.status = stpa_pkg::ST_OK;
					rsp.addr_out = hit_tun_q;
					rsp.slot_out = stpa_pkg::to_slot(hit_idx_q);
					rsp.peer_ip_out = hit_ip_q;
					rsp.peer_port_out = hit_port_q;
				end
			end
			stpa_pkg::OP_REMOVE: begin
				if (found_q) begin
					rsp.status = stpa_pkg::ST_OK;
					rsp.addr_out = hit_tun_q;
					rsp.slot_out = stpa_pkg::to_slot(hit_idx_q);
				end
			end
			stpa_pkg::OP_SWEEP: begin
				rsp.status = stpa_pkg::ST_OK;
				rsp.expired_count = stpa_pkg::to_count(expired_q);
			end
			default: rsp.status = stpa_pkg::ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			mem_tun[free_idx_q] <= cand;
			mem_ip[free_idx_q] <= req_q.peer_ip;
			mem_port[free_idx_q] <= req_q.peer_port;
		end
		tun_s1 <= mem_tun[cmd.rd_idx];
		ip_s1 <= mem_ip[cmd.rd_idx];
		port_s1 <= mem_port[cmd.rd_idx];
	end

	always_ff @(posedge clk) begin
		if (seen_we) begin
			mem_seen[seen_idx] <= req_q.now_time;
		end
		seen_s1 <= mem_seen[cmd.rd_idx];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.rd_idx;
		act_s1 <= active_q[cmd.rd_idx];
		if (cmd.load) begin
			req_q <= in_data;
		end
		if (cmd.commit) begin
			out_q <= rsp;
		end
		if (rd_en_s1 && !found_q && sel_hit) begin
			hit_idx_q <= idx_s1;
			hit_tun_q <= tun_s1;
			hit_ip_q <= ip_s1;
			hit_port_q <= port_s1;
		end
		if (rd_en_s1 && !free_found_q && !act_s1) begin
			free_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_first_q <= stpa_pkg::POOL_FIRST_RESET;
			pool_last_q <= stpa_pkg::POOL_LAST_RESET;
			timeout_q <= stpa_pkg::TIMEOUT_RESET;
			next_pool_q <= stpa_pkg::POOL_FIRST_RESET;
			active_total_q <= '0;
			active_q <= '0;
			rd_en_s1 <= 1'b0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			expired_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					stpa_pkg::REG_POOL_FIRST: pool_first_q <= cfg_data;
					stpa_pkg::REG_POOL_LAST: pool_last_q <= cfg_data;
					stpa_pkg::REG_IDLE_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end

			rd_en_s1 <= cmd.rd_en;

			if (cmd.load) begin
				found_q <= 1'b0;
				free_found_q <= 1'b0;
				expired_q <= '0;
			end else begin
				if (rd_en_s1 && sel_hit) begin
					found_q <= 1'b1;
				end
				if (rd_en_s1 && !act_s1) begin
					free_found_q <= 1'b1;
				end
			end

			// drop aged entries as the scan passes them
			if (expire) begin
				active_q[idx_s1] <= 1'b0;
				expired_q <= expired_q + 1'b1;
				if (active_total_q != '0) begin
					active_total_q <= active_total_q - 1'b1;
				end
			end

			if (do_insert) begin
				active_q[free_idx_q] <= 1'b1;
				active_total_q <= active_total_q + 1'b1;
				next_pool_q <= cand + 32'd1;
			end

			if (do_remove) begin
				active_q[hit_idx_q] <= 1'b0;
				if (active_total_q != '0) begin
					active_total_q <= active_total_q - 1'b1;
				end
			end
		end
	end

endmodule

[rtl/core/session_table_with_pool_and_aging.sv]
`timescale 1ns / 1ps
// Session table: 32 client sessions with a tunnel address pool and idle aging.
// Request channel (in_valid/in_ready/in_data) carries one operation: add peer,
// find by tunnel address, find by peer, remove, or timeout sweep. Response
// channel (out_valid/out_ready/out_data) returns exactly one result per request.
// Each request scans every slot from 0 upward, one slot per cycle through the
// registered read port of the entry memories, then passes a drain step and a
// commit step that loads the response into the output register; a new request
// is taken in the cycle after the response is loaded.
// The response sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the following request finishes its scan and
// holds in its commit step until the output register frees up.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 pool first address, 1 pool last address, 2 idle timeout); write only
// while no request is in flight. Reset clears all active bits and the session
// count, sets the pool pointer to POOL_FIRST_RESET and restores the register
// defaults; entry contents are undefined until written.

module session_table_with_pool_and_aging (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input stpa_pkg::in_req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output stpa_pkg::out_rsp_t out_data,
	input logic cfg_we,
	input logic [stpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	stpa_pkg::dp_cmd_t cmd;

	stpa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd)
	);

	stpa_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_data(out_data)
	);

endmodule

[rtl/core/stpa_chk.sv]
`timescale 1ns / 1ps
`include "session_table_with_pool_and_aging_assert.svh"

module stpa_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input stpa_pkg::out_rsp_t out_data
);

	`STPA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`STPA_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)
	`STPA_ASSERT(a_rsp_while_busy, clk, arst_n, $rose(out_valid) |-> $past(!in_ready))
	`STPA_ASSERT(a_status_range, clk, arst_n, out_valid |-> (out_data.status <= stpa_pkg::ST_NOT_FOUND))

endmodule

bind session_table_with_pool_and_aging stpa_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

[bench/session_table_with_pool_and_aging_tb.sv]
`timescale 1ns / 1ps

import stpa_pkg::*;

class session_sb;
	bit act [TABLE_ENTRIES];
	logic [31:0] tun [TABLE_ENTRIES];
	logic [31:0] pip [TABLE_ENTRIES];
	logic [15:0] pport [TABLE_ENTRIES];
	logic [31:0] seen [TABLE_ENTRIES];
	int unsigned total;
	logic [31:0] next_addr;
	logic [31:0] pool_first;
	logic [31:0] pool_last;
	logic [31:0] idle_tmo;
	out_rsp_t rsp_due [$];
	int errors;
	int n_req;
	int n_full;
	int n_refresh;
	int n_miss;
	int n_swept;
	int n_wrap;

	function new();
		foreach (act[i]) begin
			act[i] = 1'b0;
		end
		total = 0;
		next_addr = POOL_FIRST_RESET;
		pool_first = POOL_FIRST_RESET;
		pool_last = POOL_LAST_RESET;
		idle_tmo = TIMEOUT_RESET;
		errors = 0;
		n_req = 0;
		n_full = 0;
		n_refresh = 0;
		n_miss = 0;
		n_swept = 0;
		n_wrap = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		case (idx)
			REG_POOL_FIRST: pool_first = v;
			REG_POOL_LAST: pool_last = v;
			REG_IDLE_TIMEOUT: idle_tmo = v;
			default: ;
		endcase
	endfunction

	function int scan_peer(logic [31:0] ip, logic [15:0] port);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (act[i] && pip[i] == ip && pport[i] == port)
				return i;
		end
		return -1;
	endfunction

	function int scan_tunnel(logic [31:0] t);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (act[i] && tun[i] == t)
				return i;
		end
		return -1;
	endfunction

	function void drop_one();
		if (total > 0)
			total--;
	endfunction

	// Pick the tunnel address of a live session, or keep the given one.
	function logic [31:0] pick_tunnel(logic [31:0] dflt);
		int live [$];
		foreach (act[i]) begin
			if (act[i])
				live.push_back(i);
		end
		if (live.size() == 0)
			return dflt;
		return tun[live[$urandom_range(0, live.size() - 1)]];
	endfunction

	function void accept_req(in_req_t r);
		out_rsp_t o;
		logic [31:0] cand;
		logic [31:0] age;
		int k;
		int unsigned cnt;
		o = '0;
		o.status = ST_NOT_FOUND;
		cnt = 0;
		n_req++;
		case (r.op)
			OP_ADD: begin
				if (total >= TABLE_ENTRIES) begin
					o.status = ST_FULL;
					n_full++;
				end else begin
					k = scan_peer(r.peer_ip, r.peer_port);
					if (k >= 0) begin
						seen[k] = r.now_time;
						o.status = ST_REFRESHED;
						o.addr_out = tun[k];
						o.slot_out = 5'(k);
						n_refresh++;
					end else begin
						cand = next_addr;
						if (next_addr > pool_last) begin
							cand = pool_first;
							n_wrap++;
						end
						k = -1;
						for (int i = 0; i < TABLE_ENTRIES && k < 0; i++) begin
							if (!act[i])
								k = i;
						end
						if (k < 0) begin
							o.status = ST_NO_SLOT;
						end else begin
							act[k] = 1'b1;
							tun[k] = cand;
							pip[k] = r.peer_ip;
							pport[k] = r.peer_port;
							seen[k] = r.now_time;
							total++;
							next_addr = cand + 32'd1;
							o.status = ST_OK;
							o.addr_out = cand;
							o.slot_out = 5'(k);
						end
					end
				end
			end
			OP_FIND_TUN, OP_FIND_PEER, OP_REMOVE: begin
				k = (r.op == OP_FIND_PEER) ? scan_peer(r.peer_ip, r.peer_port) :
					scan_tunnel(r.tunnel_addr);
				if (k >= 0) begin
					o.status = ST_OK;
					o.addr_out = tun[k];
					o.slot_out = 5'(k);
					if (r.op == OP_REMOVE) begin
						act[k] = 1'b0;
						drop_one();
					end else begin
						o.peer_ip_out = pip[k];
						o.peer_port_out = pport[k];
					end
				end else begin
					n_miss++;
				end
			end
			OP_SWEEP: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					age = r.now_time - seen[i];
					if (act[i] && age > idle_tmo) begin
						act[i] = 1'b0;
						drop_one();
						cnt++;
					end
				end
				o.status = ST_OK;
				o.expired_count = 6'(cnt);
				n_swept += cnt;
			end
			default: ;
		endcase
		rsp_due.push_back(o);
	endfunction

	function void cmp(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_rsp(out_rsp_t got);
		out_rsp_t w;
		if (rsp_due.size() == 0) begin
			$error("response with no request outstanding: status %0d", got.status);
			errors++;
			return;
		end
		w = rsp_due.pop_front();
		cmp("status", 32'(w.status), 32'(got.status));
		cmp("addr_out", w.addr_out, got.addr_out);
		cmp("slot_out", 32'(w.slot_out), 32'(got.slot_out));
		cmp("peer_ip_out", w.peer_ip_out, got.peer_ip_out);
		cmp("peer_port_out", 32'(w.peer_port_out), 32'(got.peer_port_out));
		cmp("expired_count", 32'(w.expired_count), 32'(got.expired_count));
	endfunction
endclass

module session_table_with_pool_and_aging_tb;
	localparam int NPEERS = 40;
	localparam logic [2:0] OP_BAD_LO = 3'd5;
	localparam logic [2:0] OP_BAD_MID = 3'd6;
	localparam logic [2:0] OP_BAD_HI = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_req_t in_data;
	logic out_valid;
	logic out_ready;
	out_rsp_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	logic [31:0] peer_ip_set [NPEERS];
	logic [15:0] peer_port_set [NPEERS];
	logic [31:0] now_s;
	bit jitter;
	int hold_left = 0;
	session_sb sb;

	session_table_with_pool_and_aging dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("session_table_with_pool_and_aging_tb: done, errors");
		$finish;
	end

	// Response side: check every accepted response; with jitter on, stall in short bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_rsp(out_data);
			if (hold_left == 0 && jitter && $urandom_range(0, 4) == 0)
				hold_left = $urandom_range(1, 3);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_req(input in_req_t r);
		if (jitter && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			// line the gap up with the end of the scan now and then
			if ($urandom_range(0, 1) == 0)
				repeat ($urandom_range(30, 37)) @(posedge clk);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do
			@(posedge clk);
		while (!in_ready);
		sb.accept_req(r);
	endtask

	task automatic send(input logic [2:0] op, input logic [31:0] ip, input logic [15:0] port,
			input logic [31:0] tun, input logic [31:0] now);
		in_req_t r;
		r.op = op;
		r.peer_ip = ip;
		r.peer_port = port;
		r.tunnel_addr = tun;
		r.now_time = now;
		push_req(r);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.rsp_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_regs(input logic [31:0] first_a, input logic [31:0] last_a,
			input logic [31:0] tmo);
		cfg_we <= 1'b1;
		cfg_index <= REG_POOL_FIRST;
		cfg_data <= first_a;
		@(posedge clk);
		sb.set_reg(REG_POOL_FIRST, first_a);
		cfg_index <= REG_POOL_LAST;
		cfg_data <= last_a;
		@(posedge clk);
		sb.set_reg(REG_POOL_LAST, last_a);
		cfg_index <= REG_IDLE_TIMEOUT;
		cfg_data <= tmo;
		@(posedge clk);
		sb.set_reg(REG_IDLE_TIMEOUT, tmo);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int n, input int add_pct);
		in_req_t r;
		int k;
		int p;
		repeat (n) begin
			r.peer_ip = $urandom;
			r.peer_port = 16'($urandom);
			r.tunnel_addr = $urandom;
			now_s += $urandom_range(0, 12);
			r.now_time = ($urandom_range(0, 24) == 0) ? $urandom : now_s;
			k = $urandom_range(0, NPEERS - 1);
			if ($urandom_range(0, 9) != 0) begin
				r.peer_ip = peer_ip_set[k];
				r.peer_port = peer_port_set[k];
			end
			p = $urandom_range(0, 99);
			if (p < add_pct) begin
				r.op = OP_ADD;
			end else begin
				p = $urandom_range(0, 99);
				if (p < 26)
					r.op = OP_FIND_TUN;
				else if (p < 50)
					r.op = OP_FIND_PEER;
				else if (p < 76)
					r.op = OP_REMOVE;
				else if (p < 94)
					r.op = OP_SWEEP;
				else
					r.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
			end
			// aim most tunnel lookups at live sessions
			if ((r.op == OP_FIND_TUN || r.op == OP_REMOVE) && $urandom_range(0, 4) != 0)
				r.tunnel_addr = sb.pick_tunnel(r.tunnel_addr);
			push_req(r);
		end
	endtask

	initial begin
		logic [31:0] base;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		now_s = '0;
		jitter = 1'b1;
		foreach (peer_ip_set[i]) begin
			peer_ip_set[i] = $urandom;
			peer_port_set[i] = 16'($urandom);
		end
		peer_ip_set[0] = '0;
		peer_port_set[0] = '0;
		peer_ip_set[1] = '1;
		peer_port_set[1] = '1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unknown codes
		send(OP_FIND_TUN, '0, '0, POOL_FIRST_RESET, '0);
		send(OP_FIND_PEER, '0, '0, '0, '0);
		send(OP_REMOVE, '1, '1, '1, '1);
		send(OP_SWEEP, '0, '0, '0, '0);
		send(OP_BAD_LO, '1, '1, '1, '1);
		send(OP_BAD_MID, '0, '0, '0, '0);
		send(OP_BAD_HI, '1, '1, '1, '1);
		// add, refresh, lookups, remove, slot reuse
		send(OP_ADD, peer_ip_set[0], peer_port_set[0], '1, '0);
		send(OP_ADD, peer_ip_set[1], peer_port_set[1], '0, '1);
		send(OP_ADD, peer_ip_set[0], peer_port_set[0], '0, 32'd5);
		send(OP_FIND_TUN, '0, '0, POOL_FIRST_RESET + 32'd1, '0);
		send(OP_FIND_PEER, peer_ip_set[0], peer_port_set[0], '0, '0);
		send(OP_REMOVE, '0, '0, POOL_FIRST_RESET, '0);
		send(OP_FIND_TUN, '0, '0, POOL_FIRST_RESET, '0);
		send(OP_ADD, peer_ip_set[2], peer_port_set[2], '0, 32'd10);
		// aging below the timeout, then a real expiry
		send(OP_SWEEP, '0, '0, '0, 32'd40);
		send(OP_SWEEP, '0, '0, '0, 32'd100);
		send(OP_SWEEP, '0, '0, '0, 32'd100);
		// pool wrap to a first address above the last one, and wrap past 2^32
		settle();
		write_regs('1, POOL_FIRST_RESET + 32'd3, '0);
		send(OP_ADD, peer_ip_set[3], peer_port_set[3], '0, 32'd7);
		send(OP_ADD, peer_ip_set[4], peer_port_set[4], '0, 32'd7);
		send(OP_ADD, peer_ip_set[5], peer_port_set[5], '0, 32'd7);
		send(OP_SWEEP, '0, '0, '0, 32'd7);
		send(OP_SWEEP, '0, '0, '0, 32'd8);

		settle();
		write_regs(POOL_FIRST_RESET, POOL_LAST_RESET, TIMEOUT_RESET);
		run_phase(180, 40);

		// nothing ever expires: drive the table full
		settle();
		write_regs(32'hffff_fff0, '1, '1);
		run_phase(200, 60);

		settle();
		write_regs('0, '0, '0);
		run_phase(160, 45);

		settle();
		now_s = 32'hffff_ff80;
		write_regs($urandom, $urandom, $urandom_range(0, 200));
		run_phase(180, 45);

		settle();
		jitter = 1'b0;
		base = $urandom;
		write_regs(base, base + $urandom_range(0, 40), $urandom_range(20, 100));
		run_phase(180, 45);

		settle();
		repeat (40) @(posedge clk);
		$display("covered %0d requests: %0d refreshes, %0d table-full answers, %0d misses",
			sb.n_req, sb.n_refresh, sb.n_full, sb.n_miss);
		$display("pool wrapped %0d times, %0d sessions aged out", sb.n_wrap, sb.n_swept);
		if (sb.errors == 0 && sb.rsp_due.size() == 0) begin
			$display("session_table_with_pool_and_aging_tb: done, clean");
		end else begin
			$display("session_table_with_pool_and_aging_tb: done, errors");
		end
		$finish;
	end
endmodule

[session_table_with_pool_and_aging.f]
+incdir+rtl/core
rtl/core/stpa_pkg.sv
rtl/core/stpa_ctrl.sv
rtl/core/stpa_dp.sv
rtl/core/session_table_with_pool_and_aging.sv
rtl/core/stpa_chk.sv
bench/session_table_with_pool_and_aging_tb.sv
